// ===== src/ecbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ecbp_pkg
// Shared types and constants of the binomial call pricer.
// ----------------------------------------------------------------------------
package ecbp_pkg;

   localparam int unsigned EXP_LAST_TERM = 12;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EXP_MUL,    // term * r
      ST_EXP_DIV,    // term / k
      ST_DISC_DIV,   // 2^63 / growth
      ST_PROB_DIV,   // diff / den
      ST_RATIO_DIV,  // u / d mantissa
      ST_DPOW_MUL,   // price * d, n times
      ST_TERM_CONV,  // payoff into store
      ST_TERM_MUL,   // price * ratio
      ST_BW_READ0,   // read v[i]
      ST_BW_READ1,   // read v[i+1]
      ST_BW_MIXP,    // p * v[i+1]
      ST_BW_MIXQ,    // + q * v[i]
      ST_BW_DISC,    // * disc, write back
      ST_FINAL_RD,
      ST_FINAL,
      ST_DONE
   } state_type;

   // divider control
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
      logic [6:0]  bits;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;

   // normalise a 64-bit mantissa into [2^31,2^32)
   function automatic logic [31:0] norm_m(input logic [63:0] x);
      logic [63:0] v;
      v = x;
      for (int b = 63; b >= 32; b--) begin
         if (x[b]) begin
            v = x >> (b - 31);
            break;
         end
      end
      if (x[63:32] == 32'd0) begin
         for (int b = 31; b >= 0; b--) begin
            if (x[b]) begin
               v = x << (31 - b);
               break;
            end
         end
      end
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] norm_e(input logic [63:0] x);
      logic signed [15:0] sh;
      sh = 16'sd0;
      for (int b = 0; b <= 63; b++) begin
         if (x[b]) sh = 16'(b - 31);
      end
      return sh;
   endfunction

endpackage

// ===== src/ecbp_div.sv =====
// ----------------------------------------------------------------------------
// ecbp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecbp_div
   import ecbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [127:0] rem_ff, rem_in;
   logic [63:0]  den_ff, den_in;
   logic [63:0]  quo_ff, quo_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [127:0] sh;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh      = {rem_ff[126:0], 1'b0};
      if (req.start) begin
         // remainder starts as num; shift count sets the fixed-point result
         rem_in  = {64'd0, req.num};
         den_in  = req.den;
         quo_in  = 64'd0;
         cnt_in  = req.bits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh[127:64] >= den_ff) begin
            rem_in = {sh[127:64] - den_ff, sh[63:0]};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ===== src/european_call_binomial_pricer_core.sv =====
// ----------------------------------------------------------------------------
// european_call_binomial_pricer_core
// European call on a multi-period binomial tree, one shared multiplier.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy low; busy then stays high
// until the single result is strobed on rsp_valid for one cycle, which the
// receiver cannot stall. Everything runs through one 32x32 multiplier and a
// bit-serial divider; a transaction steps through 11 series terms (one
// multiply, then a division by k), the discount, the up probability (no
// division when it clamps), the u/d ratio, d^n, the terminal payoffs, the
// backward pass node by node, and the hand-over of the result.
// Bad factors (up not above down, or zero down) go from idle straight to
// ST_DONE, from which the strobe is registered.
// The node store is a single-port memory with registered read.
module european_call_binomial_pricer_core
   import ecbp_pkg::*;
#(
   parameter int unsigned MAX_PERIODS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_spot_price,
   input  logic [31:0] req_strike_price,
   input  logic [31:0] req_rate,
   input  logic [31:0] req_up_factor,
   input  logic [31:0] req_down_factor,
   input  logic [8:0]  req_periods,
   output logic        rsp_valid,
   output logic [31:0] rsp_call_value,
   output logic        rsp_bad_factors
);

   localparam int unsigned AW = $clog2(MAX_PERIODS + 1);

   state_type state_ff, state_in;

   logic        accept;

   logic [31:0] s_ff, k_ff, r_ff, u_ff, d_ff;
   logic [AW-1:0] n_ff;
   logic [63:0] term_ff, growth_ff;
   logic [3:0]  kk_ff;
   logic [31:0] disc_ff, p_ff;
   logic [31:0] pm_ff, rm_ff, dm_ff;     // mantissas
   logic signed [15:0] pe_ff, re_ff, de_ff;
   logic [AW-1:0] i_ff, step_ff;
   logic [31:0] va_ff;
   logic [63:0] acc_ff;
   logic [31:0] res_ff;
   logic        bad_ff, vld_ff;
   logic        sub_ff;

   // shared multiplier
   logic [31:0] ma, mb;
   logic [63:0] prod;
   assign prod = ma * mb;

   div_req_type div_req_ff, div_req_in;
   div_rsp_type drsp;
   ecbp_div u_div (.clock(clock), .reset(reset), .req(div_req_ff), .rsp(drsp));

   // node store
   logic [31:0]   mem [MAX_PERIODS+1];
   logic [AW-1:0] maddr;
   logic          mwe;
   logic [31:0]   mwd, mrd_ff;
   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mwd;
      mrd_ff <= mem[maddr];
   end

   logic [AW:0]   n_sat;
   logic [63:0]   dq, den, diff;
   logic [31:0]   q_w, pv, payoff;
   logic signed [15:0] sh;
   logic [63:0]   mnext;

   assign accept = start & ~busy;

   always_comb begin
      n_sat = (32'(req_periods) > MAX_PERIODS) ? (AW+1)'(MAX_PERIODS)
                                               : (AW+1)'(req_periods);
      dq   = {16'd0, d_ff, 16'd0};
      den  = {16'd0, u_ff - d_ff, 16'd0};
      diff = growth_ff - dq;
      q_w  = 32'h8000_0000 - p_ff;
      mnext = prod >> 32;
      // Q16.16 conversion of current price
      sh = pe_ff + 16'sd16;
      if (pm_ff == 32'd0)           pv = 32'd0;
      else if (sh >= 16'sd1)        pv = 32'hFFFF_FFFF;
      else if (sh == 16'sd0)        pv = pm_ff;
      else if (sh <= -16'sd32)      pv = 32'd0;
      else                          pv = pm_ff >> (-sh);
      payoff = (pv > k_ff) ? pv - k_ff : 32'd0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            if (req_up_factor <= req_down_factor || req_down_factor == 32'd0)
               state_in = ST_DONE;
            else state_in = ST_EXP_MUL;
         end
         ST_EXP_MUL: state_in = ST_EXP_DIV;
         ST_EXP_DIV: if (drsp.done) begin
            state_in = (kk_ff == 4'(EXP_LAST_TERM)) ? ST_DISC_DIV : ST_EXP_MUL;
         end
         ST_DISC_DIV: if (drsp.done) state_in = ST_PROB_DIV;
         ST_PROB_DIV: if (drsp.done || !sub_ff) state_in = ST_RATIO_DIV;
         ST_RATIO_DIV: if (drsp.done)
            state_in = (n_ff == '0) ? ST_TERM_CONV : ST_DPOW_MUL;
         ST_DPOW_MUL: if (i_ff == n_ff - 1'b1) state_in = ST_TERM_CONV;
         ST_TERM_CONV: state_in = (i_ff == n_ff) ?
               ((n_ff == '0) ? ST_FINAL_RD : ST_BW_READ0) : ST_TERM_MUL;
         ST_TERM_MUL: state_in = ST_TERM_CONV;
         ST_BW_READ0: state_in = ST_BW_READ1;
         ST_BW_READ1: state_in = ST_BW_MIXP;
         ST_BW_MIXP:  state_in = ST_BW_MIXQ;
         ST_BW_MIXQ:  state_in = ST_BW_DISC;
         ST_BW_DISC: begin
            if (i_ff == step_ff - 1'b1 && step_ff == AW'(1)) state_in = ST_FINAL_RD;
            else state_in = ST_BW_READ0;
         end
         ST_FINAL_RD: state_in = ST_FINAL;
         ST_FINAL:    state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      ma = 32'd0; mb = 32'd0;
      maddr = i_ff; mwe = 1'b0; mwd = payoff;
      case (state_ff)
         ST_EXP_MUL: begin ma = term_ff[31:0]; mb = r_ff; end
         ST_DPOW_MUL: begin ma = pm_ff; mb = dm_ff; end
         ST_TERM_MUL: begin ma = pm_ff; mb = rm_ff; end
         ST_TERM_CONV: mwe = 1'b1;
         ST_BW_READ1: maddr = i_ff + 1'b1;
         ST_BW_MIXP: begin ma = p_ff; mb = mrd_ff; end
         ST_BW_MIXQ: begin ma = q_w; mb = va_ff; end
         ST_BW_DISC: begin
            ma = acc_ff[62:31]; mb = disc_ff;
            mwe = 1'b1; mwd = prod[62:31];
         end
         ST_FINAL_RD: maddr = '0;
         default: ;
      endcase
   end

   // divider requests, one-cycle start pulse
   always_comb begin
      div_req_in       = div_req_ff;
      div_req_in.start = 1'b0;
      case (state_ff)
         ST_EXP_MUL: begin
            div_req_in.start = 1'b1;
            div_req_in.num   = mnext;
            div_req_in.den   = {60'd0, kk_ff};
            div_req_in.bits  = 7'd64;
         end
         ST_EXP_DIV: if (drsp.done && kk_ff == 4'(EXP_LAST_TERM)) begin
            div_req_in.start = 1'b1;
            div_req_in.num   = 64'h8000_0000_0000_0000;
            div_req_in.den   = growth_ff + drsp.quo;
            div_req_in.bits  = 7'd64;
         end
         ST_DISC_DIV: if (drsp.done && growth_ff > dq && diff < den) begin
            // diff < den < 2^48: 64+15 steps on diff*2^16 give diff*2^31/den
            div_req_in.start = 1'b1;
            div_req_in.num   = diff << 16;
            div_req_in.den   = den;
            div_req_in.bits  = 7'd79;
         end
         ST_PROB_DIV: if (drsp.done || !sub_ff) begin
            div_req_in.start = 1'b1;
            div_req_in.num   = {norm_m({32'd0, u_ff}), 32'd0};
            div_req_in.den   = {32'd0, norm_m({32'd0, d_ff})};
            div_req_in.bits  = 7'd64;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) div_req_ff <= '0;
      else       div_req_ff <= div_req_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (accept) begin
            s_ff <= req_spot_price; k_ff <= req_strike_price; r_ff <= req_rate;
            u_ff <= req_up_factor;  d_ff <= req_down_factor;
            n_ff <= AW'(n_sat);
            term_ff   <= {32'd0, req_rate};
            growth_ff <= 64'h1_0000_0000 + {32'd0, req_rate};
            kk_ff <= 4'd2;
            bad_ff <= (req_up_factor <= req_down_factor) || req_down_factor == 32'd0;
         end
         ST_EXP_DIV: if (drsp.done) begin
            term_ff   <= drsp.quo;
            growth_ff <= growth_ff + drsp.quo;
            kk_ff     <= kk_ff + 4'd1;
         end
         ST_DISC_DIV: if (drsp.done) begin
            disc_ff <= drsp.quo[31:0];
            if (growth_ff <= dq) begin
               p_ff   <= 32'd0;
               sub_ff <= 1'b0;
            end else if (diff >= den) begin
               p_ff   <= 32'h8000_0000;
               sub_ff <= 1'b0;
            end else sub_ff <= 1'b1;
         end
         ST_PROB_DIV: if (drsp.done || !sub_ff) begin
            if (sub_ff) p_ff <= drsp.quo[31:0];
            dm_ff <= norm_m({32'd0, d_ff});
            de_ff <= norm_e({32'd0, d_ff}) - 16'sd16;
            pm_ff <= norm_m({32'd0, s_ff});
            pe_ff <= (s_ff == 32'd0) ? 16'sd0 : norm_e({32'd0, s_ff}) - 16'sd16;
            re_ff <= norm_e({32'd0, u_ff}) - norm_e({32'd0, d_ff}) - 16'sd32;
            i_ff <= '0;
         end
         ST_RATIO_DIV: if (drsp.done) begin
            rm_ff <= norm_m(drsp.quo);
            re_ff <= re_ff + norm_e(drsp.quo);
         end
         ST_DPOW_MUL: begin
            if (pm_ff == 32'd0) begin pm_ff <= 32'd0; pe_ff <= 16'sd0; end
            else begin
               pm_ff <= norm_m(mnext);
               pe_ff <= pe_ff + de_ff + 16'sd32 + norm_e(mnext);
            end
            i_ff <= (i_ff == n_ff - 1'b1) ? '0 : i_ff + 1'b1;
         end
         ST_TERM_CONV: begin
            if (i_ff == n_ff) begin i_ff <= '0; step_ff <= n_ff; end
            else i_ff <= i_ff + 1'b1;
         end
         ST_TERM_MUL: begin
            if (pm_ff == 32'd0) begin pm_ff <= 32'd0; pe_ff <= 16'sd0; end
            else begin
               pm_ff <= norm_m(mnext);
               pe_ff <= pe_ff + re_ff + 16'sd32 + norm_e(mnext);
            end
         end
         ST_BW_READ1: va_ff <= mrd_ff;
         ST_BW_MIXP:  acc_ff <= prod;
         ST_BW_MIXQ:  acc_ff <= acc_ff + prod;
         ST_BW_DISC: begin
            if (i_ff == step_ff - 1'b1) begin
               i_ff <= '0; step_ff <= step_ff - 1'b1;
            end else i_ff <= i_ff + 1'b1;
         end
         ST_FINAL: res_ff <= mrd_ff;
         default: ;
      endcase
   end

   // read timing: READ0 addresses v[i], value appears in READ1; READ1
   // addresses v[i+1], value appears in MIXP
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= (state_ff == ST_DONE);
      end
   end

   logic [31:0] out_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) out_ff <= bad_ff ? 32'd0 : res_ff;
   end

   assign busy            = (state_ff != ST_IDLE) || vld_ff;
   assign rsp_valid       = vld_ff;
   assign rsp_call_value  = out_ff;
   assign rsp_bad_factors = bad_ff;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binomial European call pricer: a queue-fed
// driver, an internal price predictor and a strobe monitor.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ecbp_pkg::*;

   localparam int unsigned MAX_PERIODS  = 256;
   localparam int unsigned QUIET_ITEMS  = 20;        // tail with no idling
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam logic [31:0] Q16_ONE      = 32'h0001_0000;
   localparam logic [63:0] Q31_ONE      = 64'h8000_0000;

   typedef struct {
      logic [31:0] spot;
      logic [31:0] strike;
      logic [31:0] rate;
      logic [31:0] up;
      logic [31:0] down;
      logic [8:0]  periods;
   } option_type;

   typedef struct {
      logic [31:0] value;
      logic        bad;
   } price_type;

   // mantissa/exponent number: value = m * 2^e, m in [2^31, 2^32) or zero
   typedef struct {
      logic [31:0] m;
      int          e;
   } mexp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_spot_price   = '0;
   logic [31:0] req_strike_price = '0;
   logic [31:0] req_rate         = '0;
   logic [31:0] req_up_factor    = '0;
   logic [31:0] req_down_factor  = '0;
   logic [8:0]  req_periods      = '0;
   logic        rsp_valid;
   logic [31:0] rsp_call_value;
   logic        rsp_bad_factors;

   option_type  pending_options[$];
   price_type   expected_prices[$];
   int          total_options;
   int          accepted_count = 0;
   int          idle_left      = 0;
   int          mismatches     = 0;
   int          cycle_count    = 0;
   int unsigned cycle_limit    = 5_000_000;

   // predictor state, mirrors the block's registers
   logic [31:0] up_prob;
   logic [31:0] disc_q31;
   logic [31:0] tree[MAX_PERIODS+1];

   european_call_binomial_pricer_core #(.MAX_PERIODS(MAX_PERIODS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_spot_price(req_spot_price),
      .req_strike_price(req_strike_price),
      .req_rate(req_rate),
      .req_up_factor(req_up_factor),
      .req_down_factor(req_down_factor),
      .req_periods(req_periods),
      .rsp_valid(rsp_valid),
      .rsp_call_value(rsp_call_value),
      .rsp_bad_factors(rsp_bad_factors)
   );

   always #4 clock = ~clock;

   // ---- predictor -----------------------------------------------------------

   function automatic mexp_type mexp_norm(logic [63:0] x, int e);
      mexp_type r;
      r.m = '0;
      r.e = 0;
      if (x == 0) return r;
      while (x >= 64'h1_0000_0000) begin
         x = x >> 1;
         e++;
      end
      while (x < 64'h8000_0000) begin
         x = x << 1;
         e--;
      end
      r.m = x[31:0];
      r.e = e;
      return r;
   endfunction

   function automatic mexp_type mexp_mul(mexp_type a, mexp_type b);
      if (a.m == 0 || b.m == 0) return mexp_norm(64'd0, 0);
      return mexp_norm((64'(a.m) * 64'(b.m)) >> 32, a.e + b.e + 32);
   endfunction

   function automatic mexp_type mexp_div(mexp_type a, mexp_type b);
      if (a.m == 0 || b.m == 0) return mexp_norm(64'd0, 0);
      return mexp_norm((64'(a.m) << 32) / 64'(b.m), a.e - b.e - 32);
   endfunction

   // truncating, saturating conversion to Q16.16
   function automatic logic [31:0] mexp_to_q16(mexp_type a);
      int sh;
      if (a.m == 0) return '0;
      sh = a.e + 16;
      if (sh >= 1) return 32'hFFFF_FFFF;
      if (sh == 0) return a.m;
      if (sh <= -32) return '0;
      return a.m >> (-sh);
   endfunction

   // exp(r) in Q32.32 by a 13-term truncated series
   function automatic logic [63:0] growth_of(logic [31:0] r);
      logic [63:0] term;
      logic [63:0] sum;
      term = 64'(r);
      sum  = 64'h1_0000_0000 + term;
      for (int k = 2; k <= EXP_LAST_TERM; k++) begin
         term = ((term * 64'(r)) >> 32) / 64'(k);
         sum  = sum + term;
      end
      return sum;
   endfunction

   // floor(num * 2^31 / den), num < den
   function automatic logic [31:0] ratio_q31(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      q = '0;
      for (int k = 0; k < 31; k++) begin
         num = num << 1;
         q   = q << 1;
         if (num >= den) begin
            num  = num - den;
            q[0] = 1'b1;
         end
      end
      return q[31:0];
   endfunction

   function automatic price_type price_call(option_type o);
      price_type   res;
      logic [63:0] growth;
      logic [63:0] d_q32;
      logic [63:0] span;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] mix;
      logic [31:0] pv;
      mexp_type    d_x;
      mexp_type    step_ratio;
      mexp_type    price;
      int          n;
      res.value = '0;
      res.bad   = 1'b1;
      if (o.up <= o.down || o.down == 0) return res;   // unusable factors
      res.bad = 1'b0;
      n = (o.periods > MAX_PERIODS) ? MAX_PERIODS : int'(o.periods);

      growth   = growth_of(o.rate);
      disc_q31 = 32'((64'h1 << 63) / growth);
      d_q32    = 64'(o.down) << 16;
      span     = 64'(o.up - o.down) << 16;
      if (growth <= d_q32) up_prob = '0;                 // clamp at zero
      else if (growth - d_q32 >= span) up_prob = Q31_ONE[31:0];  // clamp at one
      else up_prob = ratio_q31(growth - d_q32, span);
      p = 64'(up_prob);
      q = Q31_ONE - p;

      // terminal payoffs, lowest node first, stepping by u/d
      d_x        = mexp_norm(64'(o.down), -16);
      step_ratio = mexp_div(mexp_norm(64'(o.up), -16), d_x);
      price      = mexp_norm(64'(o.spot), -16);
      for (int i = 0; i < n; i++) price = mexp_mul(price, d_x);
      for (int i = 0; i <= n; i++) begin
         pv      = mexp_to_q16(price);
         tree[i] = (pv > o.strike) ? pv - o.strike : '0;
         price   = mexp_mul(price, step_ratio);
      end

      // backward induction
      for (int s = n; s > 0; s--) begin
         for (int i = 0; i < s; i++) begin
            mix     = (p * 64'(tree[i+1]) + q * 64'(tree[i])) >> 31;
            tree[i] = 32'((mix * 64'(disc_q31)) >> 31);
         end
      end
      res.value = tree[0];
      return res;
   endfunction

   // ---- stimulus ------------------------------------------------------------

   function automatic option_type mk_option(logic [31:0] s, logic [31:0] k, logic [31:0] r,
                                            logic [31:0] u, logic [31:0] d, logic [8:0] n);
      option_type o;
      o.spot    = s;
      o.strike  = k;
      o.rate    = r;
      o.up      = u;
      o.down    = d;
      o.periods = n;
      return o;
   endfunction

   // plausible market: u above one, d near 1/u, small rate, prices from 20 to just over 300
   function automatic option_type market_option(logic [8:0] n);
      logic [31:0] u;
      logic [31:0] d;
      u = Q16_ONE + $urandom_range(50, 16000);
      d = 32'(64'h1_0000_0000 / 64'(u));
      if ($urandom_range(0, 5) == 0) d = d + $urandom_range(0, 20000);  // arbitrage edges
      return mk_option((32'($urandom_range(20, 300)) << 16) | 32'($urandom_range(0, 65535)),
                       (32'($urandom_range(20, 300)) << 16) | 32'($urandom_range(0, 65535)),
                       $urandom_range(0, 32'h0800_0000), u, d, n);
   endfunction

   initial begin
      logic [8:0]  n;
      int unsigned n_eff;
      // directed: bad factors
      pending_options.push_back(mk_option('0, '0, '0, '0, '0, 9'd0));
      pending_options.push_back(mk_option(100 << 16, 90 << 16, 1000, Q16_ONE, Q16_ONE, 9'd4));
      pending_options.push_back(mk_option(100 << 16, 90 << 16, 1000, 32'h0000_F000, Q16_ONE,
                                          9'd4));
      pending_options.push_back(mk_option(100 << 16, 90 << 16, 1000, 32'hFFFF_FFFF, '0, 9'd4));
      pending_options.push_back(mk_option('1, '1, '1, '1, '1, 9'h1FF));
      // zero periods: payoff on spot, in and out of the money
      pending_options.push_back(mk_option(120 << 16, 100 << 16, 5000, 32'h0001_2000,
                                          32'h0000_E000, 9'd0));
      pending_options.push_back(mk_option(80 << 16, 100 << 16, 5000, 32'h0001_2000,
                                          32'h0000_E000, 9'd0));
      // ordinary small trees
      pending_options.push_back(mk_option(100 << 16, 100 << 16, 32'h0100_0000, 32'h0001_1999,
                                          32'h0000_E8BA, 9'd1));
      pending_options.push_back(mk_option(100 << 16, 95 << 16, 32'h0100_0000, 32'h0001_1999,
                                          32'h0000_E8BA, 9'd2));
      pending_options.push_back(mk_option(100 << 16, 105 << 16, 32'h0080_0000, 32'h0001_0800,
                                          32'h0000_F800, 9'd10));
      // probability clamps: growth below d, growth above u
      pending_options.push_back(mk_option(100 << 16, 90 << 16, '0, 32'h0002_0000,
                                          32'h0001_8000, 9'd3));
      pending_options.push_back(mk_option(100 << 16, 90 << 16, '1, 32'h0001_1999,
                                          32'h0000_8000, 9'd3));
      // extremes of spot, strike and factors; saturation of prices
      pending_options.push_back(mk_option('1, '0, '0, '1, 32'd1, 9'd3));
      pending_options.push_back(mk_option('1, '0, '1, '1, Q16_ONE, 9'd5));
      pending_options.push_back(mk_option('0, '0, 32'h0100_0000, 32'h0001_2000,
                                          32'h0000_E000, 9'd6));
      pending_options.push_back(mk_option('1, '1, '0, 32'h0001_0001, Q16_ONE, 9'd7));
      pending_options.push_back(mk_option(32'd1, '0, '1, 32'd2, 32'd1, 9'd2));
      // deepest trees, and a period count past the maximum
      pending_options.push_back(mk_option(100 << 16, 100 << 16, 32'h0040_0000, 32'h0001_0400,
                                          32'h0000_FC00, 9'd256));
      pending_options.push_back(mk_option(100 << 16, 100 << 16, 32'h0040_0000, 32'h0001_0400,
                                          32'h0000_FC00, 9'h1FF));

      // random part: mostly plausible markets with small trees
      for (int i = 0; i < 81; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin   // raw fields, shallow
               n = 9'($urandom_range(0, 30));
               if ($urandom_range(0, 1)) n = n | 9'h100;
               if (n > 9'd256 || n == 9'd256) n = 9'($urandom_range(0, 30));
               pending_options.push_back(mk_option($urandom, $urandom, $urandom, $urandom,
                                                   $urandom, n));
            end
            2: pending_options.push_back(market_option(9'($urandom_range(25, 80))));
            default: begin
               n = 9'($urandom_range(0, 24));
               if ($urandom_range(0, 199) == 0) n = 9'($urandom_range(200, 511));
               pending_options.push_back(market_option(n));
            end
         endcase
      end
      total_options = pending_options.size();

      // generous bound: four times a per-transaction worst case
      cycle_limit = 100_000;
      foreach (pending_options[j]) begin
         n_eff = (pending_options[j].periods > MAX_PERIODS) ? MAX_PERIODS
                                                             : pending_options[j].periods;
         cycle_limit += 4 * (3 * n_eff * (n_eff + 1) + 4 * n_eff + 1_200);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ---- driver ----------------------------------------------------------------
   // A transaction is taken at an edge where start was high and busy low; the
   // next option is presented in the same step, so start never dips between
   // back-to-back transactions.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_prices.push_back(price_call(pending_options.pop_front()));
            accepted_count++;
            if (accepted_count < total_options - QUIET_ITEMS && $urandom_range(0, 3) == 0)
               idle_left = $urandom_range(1, 7);
         end
         if (start && busy) begin
            // hold the presented option until the block takes it
         end else if (idle_left > 0) begin
            start <= 1'b0;
            idle_left--;
         end else if (pending_options.size() > 0) begin
            req_spot_price   <= pending_options[0].spot;
            req_strike_price <= pending_options[0].strike;
            req_rate         <= pending_options[0].rate;
            req_up_factor    <= pending_options[0].up;
            req_down_factor  <= pending_options[0].down;
            req_periods      <= pending_options[0].periods;
            start            <= 1'b1;
            if (accepted_count < total_options - QUIET_ITEMS && $urandom_range(0, 7) == 0)
               idle_left = $urandom_range(1, 7);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---- monitor ---------------------------------------------------------------
   always @(posedge clock) begin
      price_type want;
      if (!reset && rsp_valid) begin
         if (expected_prices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %h bad %b", rsp_call_value, rsp_bad_factors);
         end else begin
            want = expected_prices.pop_front();
            if (rsp_call_value !== want.value || rsp_bad_factors !== want.bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected value %h bad %b, got value %h bad %b",
                           accepted_count, want.value, want.bad, rsp_call_value,
                           rsp_bad_factors);
            end
         end
      end
   end

   // ---- watchdog ----------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= cycle_limit) begin
         $display("european_call_binomial_pricer_core: mismatch");
         $finish;
      end
   end

   // ---- end of run ------------------------------------------------------------
   initial begin
      @(negedge reset);
      while (pending_options.size() > 0 || expected_prices.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_prices.size() == 0) begin
         $display("european_call_binomial_pricer_core: match");
      end else begin
         $display("european_call_binomial_pricer_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== european_call_binomial_pricer_core.f =====
src/ecbp_pkg.sv
src/ecbp_div.sv
src/european_call_binomial_pricer_core.sv
tb/sv/tb.sv
